[sv/vwfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwfa_pkg
// Shared types, codes and normalization helpers of the variable width
// integer fold ALU.
// ----------------------------------------------------------------------------
package vwfa_pkg;

   localparam int XLEN          = 64;
   localparam int WIDTH_BITS    = 7;
   localparam int DEF_DATA_WIDTH = 64;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      ACT_ADD   = 5'd0,
      ACT_SUB   = 5'd1,
      ACT_MUL   = 5'd2,
      ACT_AND   = 5'd3,
      ACT_OR    = 5'd4,
      ACT_XOR   = 5'd5,
      ACT_SHL   = 5'd6,
      ACT_LSHR  = 5'd7,
      ACT_ASHR  = 5'd8,
      ACT_SDIV  = 5'd9,
      ACT_SREM  = 5'd10,
      ACT_UDIV  = 5'd11,
      ACT_UREM  = 5'd12,
      ACT_NEG   = 5'd13,
      ACT_NOT   = 5'd14,
      ACT_EQ    = 5'd15,
      ACT_NE    = 5'd16,
      ACT_SLT   = 5'd17,
      ACT_SLE   = 5'd18,
      ACT_ULT   = 5'd19,
      ACT_ULE   = 5'd20,
      ACT_TRUNC = 5'd21,
      ACT_SEXT  = 5'd22,
      ACT_ZEXT  = 5'd23
   } action_type;

   // A classified request as it waits between the front and the back.
   typedef struct packed {
      action_type             action;
      logic [XLEN-1:0]        a;
      logic [XLEN-1:0]        b;
      logic [XLEN-1:0]        sa;
      logic [XLEN-1:0]        sb;
      logic [XLEN-1:0]        ua;
      logic [XLEN-1:0]        ub;
      logic [WIDTH_BITS-1:0]  w;
      logic [WIDTH_BITS-1:0]  dw;
      logic                   shift_ok;
   } item_type;

   // The width w is always 1 to 64 here.
   function automatic logic [XLEN-1:0] width_mask(logic [WIDTH_BITS-1:0] w);
      logic [WIDTH_BITS-1:0] sh;
      sh = WIDTH_BITS'(XLEN) - w;
      return {XLEN{1'b1}} >> sh;
   endfunction

   function automatic logic [XLEN-1:0] low_bits(logic [XLEN-1:0] v,
                                                logic [WIDTH_BITS-1:0] w);
      return v & width_mask(w);
   endfunction

   function automatic logic [XLEN-1:0] sign_fill(logic [XLEN-1:0] v,
                                                 logic [WIDTH_BITS-1:0] w);
      logic [XLEN-1:0] m;
      logic [5:0]      top;
      m   = width_mask(w);
      top = 6'(w - 7'd1);
      return v[top] ? (v | ~m) : (v & m);
   endfunction

   // Width one keeps bit 0 alone; every other width sign-extends.
   function automatic logic [XLEN-1:0] norm(logic [XLEN-1:0] v,
                                            logic [WIDTH_BITS-1:0] w);
      if (w == 7'd1) begin
         return {{(XLEN-1){1'b0}}, v[0]};
      end
      return sign_fill(v, w);
   endfunction

endpackage

[sv/vwfa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwfa_front
// Request classifier: clamps the widths, forms the signed and unsigned
// views of both operands and checks the shift range.
// ----------------------------------------------------------------------------
module vwfa_front #(
   parameter int DATA_WIDTH = vwfa_pkg::DEF_DATA_WIDTH
) (
   input  logic [4:0]                      action,
   input  logic [vwfa_pkg::XLEN-1:0]       operand_a,
   input  logic [vwfa_pkg::XLEN-1:0]       operand_b,
   input  logic [vwfa_pkg::WIDTH_BITS-1:0] width,
   input  logic [vwfa_pkg::WIDTH_BITS-1:0] dest_width,
   output vwfa_pkg::item_type              item
);
   import vwfa_pkg::*;

   localparam logic [WIDTH_BITS-1:0] MaxW = WIDTH_BITS'(DATA_WIDTH);

   logic [WIDTH_BITS-1:0] w;
   logic [WIDTH_BITS-1:0] dw;

   always_comb begin
      w = (width == '0) ? 7'd1 : ((width > MaxW) ? MaxW : width);
      dw = (dest_width == '0) ? 7'd1 : ((dest_width > MaxW) ? MaxW : dest_width);
   end

   always_comb begin
      item.action   = action_type'(action);
      item.a        = operand_a;
      item.b        = operand_b;
      item.w        = w;
      item.dw       = dw;
      item.sa       = sign_fill(operand_a, w);
      item.sb       = sign_fill(operand_b, w);
      item.ua       = low_bits(operand_a, w);
      item.ub       = low_bits(operand_b, w);
      // A negative amount or one of width or more is out of range.
      item.shift_ok = !operand_b[XLEN-1] && (operand_b < XLEN'(w));
   end

endmodule

[sv/vwfa_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwfa_queue
// Short request queue between the classifier and the execution pipeline.
// ----------------------------------------------------------------------------
module vwfa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vwfa_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output vwfa_pkg::item_type head
);
   import vwfa_pkg::*;

   item_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/vwfa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwfa_back
// Execution pipeline: simple operations and multiplier partial
// products in the first stage, one quotient bit per divider stage, and a
// final stage that applies signs, normalizes and holds the result.
// ----------------------------------------------------------------------------
module vwfa_back #(
   parameter int DATA_WIDTH = vwfa_pkg::DEF_DATA_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  vwfa_pkg::item_type          q_head,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [vwfa_pkg::XLEN-1:0]   rsp_result,
   output logic                        rsp_folded
);
   import vwfa_pkg::*;

   localparam int DW = DATA_WIDTH;

   typedef struct packed {
      action_type            action;
      logic [WIDTH_BITS-1:0] w;
      logic                  ok;
      logic [XLEN-1:0]       value;
      logic                  na;
      logic                  nb;
   } lane_type;

   // Index 0 is the first stage; 1 to DW are the divider steps.
   lane_type        lane_ff  [DW+1];
   logic            valid_ff [DW+1];
   logic [DW-1:0]   rem_ff   [DW+1];
   logic [DW-1:0]   num_ff   [DW+1];
   logic [DW-1:0]   den_ff   [DW];

   logic [XLEN-1:0] pp_ll_ff, pp_ll_in;
   logic [31:0]     pp_lh_ff, pp_lh_in;
   logic [31:0]     pp_hl_ff, pp_hl_in;

   lane_type        lane0_in;
   logic [DW-1:0]   num0_in;
   logic [DW-1:0]   den0_in;

   logic [XLEN-1:0] result_ff, result_in;
   logic            folded_ff, folded_in;
   logic            out_valid_ff;
   logic            adv;

   // The whole pipeline moves together whenever the output slot frees up.
   assign adv        = !out_valid_ff || rsp_pop;
   assign q_pop      = adv && !q_empty;
   assign rsp_empty  = !out_valid_ff;
   assign rsp_result = result_ff;
   assign rsp_folded = folded_ff;

   // ---------------- first stage ----------------
   always_comb begin
      logic [XLEN-1:0] r;
      logic            ok;
      logic [5:0]      s;
      logic [XLEN-1:0] minw;
      logic [XLEN-1:0] ma;
      logic [XLEN-1:0] mb;
      logic            is_signed;
      r         = '0;
      ok        = 1'b1;
      s         = q_head.b[5:0];
      minw      = {XLEN{1'b1}} << 6'(q_head.w - 7'd1);
      ma        = q_head.sa[XLEN-1] ? (XLEN'(0) - q_head.sa) : q_head.sa;
      mb        = q_head.sb[XLEN-1] ? (XLEN'(0) - q_head.sb) : q_head.sb;
      is_signed = (q_head.action == ACT_SDIV) || (q_head.action == ACT_SREM);
      case (q_head.action)
         ACT_ADD:  r = norm(q_head.a + q_head.b, q_head.w);
         ACT_SUB:  r = norm(q_head.a - q_head.b, q_head.w);
         ACT_MUL:  r = '0;
         ACT_AND:  r = norm(q_head.a & q_head.b, q_head.w);
         ACT_OR:   r = norm(q_head.a | q_head.b, q_head.w);
         ACT_XOR:  r = norm(q_head.a ^ q_head.b, q_head.w);
         ACT_SHL: begin
            ok = q_head.shift_ok;
            r  = norm(q_head.a << s, q_head.w);
         end
         ACT_LSHR: begin
            ok = q_head.shift_ok;
            r  = norm(q_head.ua >> s, q_head.w);
         end
         ACT_ASHR: begin
            ok = q_head.shift_ok;
            r  = norm(XLEN'($signed(q_head.sa) >>> s), q_head.w);
         end
         ACT_SDIV, ACT_SREM: begin
            ok = !((q_head.sb == '0) ||
                   ((q_head.sb == {XLEN{1'b1}}) && (q_head.sa == minw)));
         end
         ACT_UDIV, ACT_UREM: ok = (q_head.ub != '0);
         ACT_NEG:  r = norm(XLEN'(0) - q_head.a, q_head.w);
         ACT_NOT:  r = norm(~q_head.a, q_head.w);
         ACT_EQ:   r = XLEN'(q_head.ua == q_head.ub);
         ACT_NE:   r = XLEN'(q_head.ua != q_head.ub);
         ACT_SLT:  r = XLEN'($signed(q_head.sa) < $signed(q_head.sb));
         ACT_SLE:  r = XLEN'($signed(q_head.sa) <= $signed(q_head.sb));
         ACT_ULT:  r = XLEN'(q_head.ua < q_head.ub);
         ACT_ULE:  r = XLEN'(q_head.ua <= q_head.ub);
         ACT_TRUNC, ACT_SEXT, ACT_ZEXT: begin
            if (q_head.dw == q_head.w) begin
               r = norm(q_head.a, q_head.w);
            end else if (q_head.action == ACT_TRUNC) begin
               r = norm(q_head.a, q_head.dw);
            end else if (q_head.action == ACT_SEXT) begin
               r = norm(q_head.sa, q_head.dw);
            end else begin
               r = norm(q_head.ua, q_head.dw);
            end
         end
         default: ok = 1'b0;
      endcase

      lane0_in.action = q_head.action;
      lane0_in.w      = q_head.w;
      lane0_in.ok     = ok;
      lane0_in.value  = r;
      lane0_in.na     = q_head.sa[XLEN-1];
      lane0_in.nb     = q_head.sb[XLEN-1];
      // Magnitudes and unsigned views at a clamped width fit in DW bits.
      num0_in = is_signed ? ma[DW-1:0] : q_head.ua[DW-1:0];
      den0_in = is_signed ? mb[DW-1:0] : q_head.ub[DW-1:0];

      pp_ll_in = XLEN'(q_head.a[31:0] * q_head.b[31:0]);
      pp_lh_in = 32'(q_head.a[31:0] * q_head.b[63:32]);
      pp_hl_in = 32'(q_head.a[63:32] * q_head.b[31:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff[0] <= lane0_in;
         rem_ff[0]  <= '0;
         num_ff[0]  <= num0_in;
         den_ff[0]  <= den0_in;
         pp_ll_ff   <= pp_ll_in;
         pp_lh_ff   <= pp_lh_in;
         pp_hl_ff   <= pp_hl_in;
      end
   end

   // ---------------- divider steps ----------------
   for (genvar k = 1; k <= DW; k++) begin : g_step
      logic [DW:0]   t;
      logic          ge;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic [DW-1:0] num_in;
      lane_type      lane_in;

      always_comb begin
         t       = {rem_ff[k-1], num_ff[k-1][DW-1]};
         diff    = t - {1'b0, den_ff[k-1]};
         ge      = (t >= {1'b0, den_ff[k-1]});
         rem_in  = ge ? diff[DW-1:0] : t[DW-1:0];
         num_in  = {num_ff[k-1][DW-2:0], ge};
         lane_in = lane_ff[k-1];
         // The product's cross terms are folded in on the first step.
         if ((k == 1) && (lane_ff[k-1].action == ACT_MUL)) begin
            lane_in.value = norm(pp_ll_ff + {pp_lh_ff + pp_hl_ff, 32'd0},
                                 lane_ff[k-1].w);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            lane_ff[k] <= lane_in;
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= num_in;
         end
      end

      // The last step has no later step that needs the divisor.
      if (k < DW) begin : g_den
         always_ff @(posedge clock) begin
            if (adv) begin
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   // ---------------- result stage ----------------
   always_comb begin
      logic [XLEN-1:0] qx;
      logic [XLEN-1:0] rx;
      logic [XLEN-1:0] v;
      lane_type        ln;
      ln = lane_ff[DW];
      qx = XLEN'(num_ff[DW]);
      rx = XLEN'(rem_ff[DW]);
      case (ln.action)
         ACT_SDIV: v = norm((ln.na != ln.nb) ? (XLEN'(0) - qx) : qx, ln.w);
         ACT_SREM: v = norm(ln.na ? (XLEN'(0) - rx) : rx, ln.w);
         ACT_UDIV: v = norm(qx, ln.w);
         ACT_UREM: v = norm(rx, ln.w);
         default:  v = ln.value;
      endcase
      result_in = ln.ok ? v : '0;
      folded_in = ln.ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= valid_ff[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff <= result_in;
         folded_ff <= folded_in;
      end
   end

endmodule

[sv/variable_width_integer_fold_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_width_integer_fold_alu
// Folds one integer operation at a width of 1 to 64 bits per request and
// returns the normalized value with a flag that says whether it folded.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Handshake
//  request   req_action/operand_a/operand_b/width/   req_push, req_full
//            req_dest_width
//  response  rsp_result, rsp_folded                  rsp_empty, rsp_pop
//
// One request enters per cycle while req_full is low, and one response
// leaves per cycle while rsp_pop is high. Each request passes from the
// queue through the first stage, the DATA_WIDTH divider steps (one
// quotient bit each) and the result register. Every request passes
// through the divider pipeline, so order is kept. Reset clears the queue
// and all pipeline valid bits. A held response stalls the pipeline; the
// four-entry queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module variable_width_integer_fold_alu #(
   parameter int DATA_WIDTH = vwfa_pkg::DEF_DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [4:0]                            req_action,
   input  logic signed [vwfa_pkg::XLEN-1:0]      req_operand_a,
   input  logic signed [vwfa_pkg::XLEN-1:0]      req_operand_b,
   input  logic [vwfa_pkg::WIDTH_BITS-1:0]       req_width,
   input  logic [vwfa_pkg::WIDTH_BITS-1:0]       req_dest_width,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [vwfa_pkg::XLEN-1:0]      rsp_result,
   output logic                                  rsp_folded
);
   import vwfa_pkg::*;

   item_type        front_item;
   item_type        q_head;
   logic            q_empty;
   logic            q_pop;
   logic [XLEN-1:0] result;

   vwfa_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .action     (req_action),
      .operand_a  (req_operand_a),
      .operand_b  (req_operand_b),
      .width      (req_width),
      .dest_width (req_dest_width),
      .item       (front_item)
   );

   vwfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   vwfa_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_result (result),
      .rsp_folded (rsp_folded)
   );

   assign rsp_result = $signed(result);

endmodule

[sim/variable_width_integer_fold_alu_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_width_integer_fold_alu_tb
// Drives directed and random fold requests through the ALU with bursty
// pushes and stalled pops, predicts each response and checks it in order.
// ----------------------------------------------------------------------------
module variable_width_integer_fold_alu_tb;
   import vwfa_pkg::*;

   localparam int LATENCY = DEF_DATA_WIDTH + 3;
   localparam int NUM_RANDOM = 1530;

   typedef struct {
      logic [4:0]  action;
      logic [63:0] a;
      logic [63:0] b;
      logic [6:0]  w;
      logic [6:0]  dw;
   } fold_request_type;

   typedef struct {
      logic [63:0] result;
      logic        folded;
   } fold_answer_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [4:0]  req_action;
   logic signed [63:0] req_operand_a;
   logic signed [63:0] req_operand_b;
   logic [6:0]  req_width;
   logic [6:0]  req_dest_width;
   logic        rsp_empty;
   logic        rsp_pop;
   logic signed [63:0] rsp_result;
   logic        rsp_folded;

   fold_request_type pending_requests[$];
   fold_answer_type  expected_answers[$];
   int          error_count;
   bit          stimulus_done;
   bit          hold_pops;
   bit          req_taken;
   int          burst_left;
   int          gap_left;

   variable_width_integer_fold_alu DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_action(req_action), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .req_width(req_width),
      .req_dest_width(req_dest_width),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_result(rsp_result), .rsp_folded(rsp_folded)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int fit_width(logic [6:0] w);
      if (w == 0) return 1;
      if (w > 64) return 64;
      return w;
   endfunction

   function automatic logic [63:0] keep_low(logic [63:0] v, int w);
      if (w >= 64) return v;
      return v & ((64'd1 << w) - 64'd1);
   endfunction

   function automatic logic [63:0] extend_signed(logic [63:0] v, int w);
      logic [63:0] m;
      if (w >= 64) return v;
      m = 64'd1 << (w - 1);
      return (keep_low(v, w) ^ m) - m;
   endfunction

   function automatic logic [63:0] fit_value(logic [63:0] v, int w);
      if (w == 1) return {63'd0, v[0]};
      return extend_signed(v, w);
   endfunction

   function automatic fold_answer_type fold_predict(fold_request_type rq);
      fold_answer_type ans;
      int          w;
      int          dw;
      logic [63:0] sa;
      logic [63:0] sb;
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] r;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] q;
      logic        ok;
      logic        shift_ok;
      w  = fit_width(rq.w);
      dw = fit_width(rq.dw);
      sa = extend_signed(rq.a, w);
      sb = extend_signed(rq.b, w);
      ua = keep_low(rq.a, w);
      ub = keep_low(rq.b, w);
      shift_ok = !rq.b[63] && rq.b < 64'(w);
      r  = '0;
      ok = 1'b1;
      case (rq.action)
         ACT_ADD: r = fit_value(rq.a + rq.b, w);
         ACT_SUB: r = fit_value(rq.a - rq.b, w);
         ACT_MUL: r = fit_value(rq.a * rq.b, w);
         ACT_AND: r = fit_value(rq.a & rq.b, w);
         ACT_OR:  r = fit_value(rq.a | rq.b, w);
         ACT_XOR: r = fit_value(rq.a ^ rq.b, w);
         ACT_SHL: if (shift_ok) r = fit_value(rq.a << rq.b[5:0], w); else ok = 1'b0;
         ACT_LSHR: if (shift_ok) r = fit_value(ua >> rq.b[5:0], w); else ok = 1'b0;
         ACT_ASHR: if (shift_ok) r = fit_value($signed(sa) >>> rq.b[5:0], w);
                   else ok = 1'b0;
         ACT_SDIV, ACT_SREM: begin
            if (sb == 0 || (sb == '1 && sa == extend_signed(64'd1 << (w - 1), w))) begin
               ok = 1'b0;
            end else begin
               ma = sa[63] ? -sa : sa;
               mb = sb[63] ? -sb : sb;
               if (rq.action == ACT_SDIV) begin
                  q = ma / mb;
                  r = fit_value((sa[63] != sb[63]) ? -q : q, w);
               end else begin
                  q = ma % mb;
                  r = fit_value(sa[63] ? -q : q, w);
               end
            end
         end
         ACT_UDIV: if (ub == 0) ok = 1'b0; else r = fit_value(ua / ub, w);
         ACT_UREM: if (ub == 0) ok = 1'b0; else r = fit_value(ua % ub, w);
         ACT_NEG: r = fit_value(-rq.a, w);
         ACT_NOT: r = fit_value(~rq.a, w);
         ACT_EQ:  r = 64'(ua == ub);
         ACT_NE:  r = 64'(ua != ub);
         ACT_SLT: r = 64'($signed(sa) < $signed(sb));
         ACT_SLE: r = 64'($signed(sa) <= $signed(sb));
         ACT_ULT: r = 64'(ua < ub);
         ACT_ULE: r = 64'(ua <= ub);
         ACT_TRUNC, ACT_SEXT, ACT_ZEXT: begin
            if (dw == w) r = fit_value(rq.a, w);
            else if (rq.action == ACT_TRUNC) r = fit_value(rq.a, dw);
            else if (rq.action == ACT_SEXT) r = fit_value(sa, dw);
            else r = fit_value(ua, dw);
         end
         default: ok = 1'b0;
      endcase
      ans.result = ok ? r : 64'd0;
      ans.folded = ok;
      return ans;
   endfunction

   function automatic logic [63:0] pick_operand(int w);
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = 64'd0;
         1: v = '1;
         2: v = 64'd1 << (w - 1);
         3: v = (64'd1 << (w - 1)) - 64'd1;
         4: v = 64'($urandom_range(0, 8));
         5: v = v >> $urandom_range(0, 63);
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_request(logic [4:0] act, logic [63:0] a, logic [63:0] b,
                              logic [6:0] w, logic [6:0] dw);
      fold_request_type rq;
      rq.action = act;
      rq.a      = a;
      rq.b      = b;
      rq.w      = w;
      rq.dw     = dw;
      pending_requests = {pending_requests, rq};
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      int          w;
      logic [63:0] b;
      add_request(ACT_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1, 7'd64, 7'd1);
      add_request(ACT_SUB, 64'h8000_0000_0000_0000, 64'd1, 7'd0, 7'd0);
      add_request(ACT_MUL, '1, '1, 7'd127, 7'd3);
      add_request(ACT_SHL, 64'd5, 64'd7, 7'd8, 7'd8);
      add_request(ACT_LSHR, '1, 64'd8, 7'd8, 7'd8);
      add_request(ACT_ASHR, 64'h80, 64'd3, 7'd8, 7'd8);
      add_request(ACT_SHL, 64'd1, '1, 7'd64, 7'd8);
      add_request(ACT_ASHR, 64'd1, 64'd64, 7'd64, 7'd8);
      add_request(ACT_SDIV, 64'h80, '1, 7'd8, 7'd8);
      add_request(ACT_SREM, 64'h8000_0000_0000_0000, '1, 7'd64, 7'd8);
      add_request(ACT_SDIV, 64'hf9, 64'd2, 7'd8, 7'd8);
      add_request(ACT_SREM, 64'hf9, 64'd2, 7'd8, 7'd8);
      add_request(ACT_UDIV, 64'd9, 64'h100, 7'd8, 7'd8);
      add_request(ACT_UREM, 64'd9, 64'd4, 7'd8, 7'd8);
      add_request(ACT_NEG, 64'h8000_0000_0000_0000, 64'd0, 7'd64, 7'd8);
      add_request(ACT_NOT, 64'd0, 64'd0, 7'd1, 7'd8);
      add_request(ACT_EQ, 64'h1ff, 64'hff, 7'd8, 7'd8);
      add_request(ACT_NE, 64'd1, 64'd2, 7'd8, 7'd8);
      add_request(ACT_SLT, 64'h80, 64'd1, 7'd8, 7'd8);
      add_request(ACT_SLE, 64'd3, 64'd3, 7'd8, 7'd8);
      add_request(ACT_ULT, 64'h80, 64'd1, 7'd8, 7'd8);
      add_request(ACT_ULE, 64'd4, 64'd3, 7'd8, 7'd8);
      add_request(ACT_TRUNC, 64'h1ff, 64'd0, 7'd16, 7'd4);
      add_request(ACT_SEXT, 64'h80, 64'd0, 7'd8, 7'd64);
      add_request(ACT_ZEXT, 64'h80, 64'd0, 7'd8, 7'd8);
      add_request(5'd31, '1, '1, 7'd64, 7'd64);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         case ($urandom_range(0, 3))
            0: w = 64;
            1: w = $urandom_range(1, 4);
            default: w = $urandom_range(1, 64);
         endcase
         b = pick_operand(w);
         if ($urandom_range(0, 2) == 0) b = 64'($urandom_range(0, w));
         add_request(($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
                                                  : 5'($urandom_range(0, 23)),
                     pick_operand(w), b,
                     ($urandom_range(0, 29) == 0) ? 7'($urandom_range(0, 127)) : 7'(w),
                     ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(1, 64)));
      end
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Records whether the request on the ports was taken at this edge.
   always @(posedge clock) begin
      if (reset) req_taken <= 1'b0;
      else req_taken <= req_push && !req_full;
   end

   // Sender: bursts of pushes separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_push       <= 1'b0;
         req_action     <= '0;
         req_operand_a  <= '0;
         req_operand_b  <= '0;
         req_width      <= 7'd1;
         req_dest_width <= 7'd1;
         burst_left     <= 0;
         gap_left       <= 0;
      end else if (!req_push || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_push <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            fold_request_type rq;
            rq = pending_requests.pop_front();
            expected_answers = {expected_answers, fold_predict(rq)};
            req_push       <= 1'b1;
            req_action     <= rq.action;
            req_operand_a  <= rq.a;
            req_operand_b  <= rq.b;
            req_width      <= rq.w;
            req_dest_width <= rq.dw;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_push      <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // The receiver stalls on its own pattern and holds off once for a long time.
   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !hold_pops && ($urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 0);
   end

   initial begin
      hold_pops = 1'b0;
      wait (!reset);
      repeat (400) @(posedge clock);
      hold_pops = 1'b1;
      repeat (300) @(posedge clock);
      hold_pops = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected response", rsp_result, 64'd0);
         end else begin
            fold_answer_type ex;
            ex = expected_answers.pop_front();
            if (rsp_result !== ex.result) report_mismatch("result", rsp_result, ex.result);
            if (rsp_folded !== ex.folded) report_mismatch("folded", 64'(rsp_folded),
                                                          64'(ex.folded));
         end
      end
   end

   initial begin
      error_count   = 0;
      stimulus_done = 1'b0;
      wait (stimulus_done && expected_answers.size() == 0);
      repeat (LATENCY * 2) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[variable_width_integer_fold_alu.f]
sv/vwfa_pkg.sv
sv/vwfa_front.sv
sv/vwfa_queue.sv
sv/vwfa_back.sv
sv/variable_width_integer_fold_alu.sv
sim/variable_width_integer_fold_alu_tb.sv
